### hdl/rwq_pkg.sv
// rwq_pkg: shared types and constants for the rolling window quantile unit
// used by rwq_cell, rwq_chain and rolling_window_quantile_unit; no dependencies
`timescale 1ns / 1ps

package rwq_pkg;

   localparam int WINDOW_MAX   = 32;
   localparam int SAMPLE_WIDTH = 16;
   localparam int IDX_W        = $clog2(WINDOW_MAX);
   localparam int CNT_W        = IDX_W + 1;
   localparam int AGE_W        = IDX_W;
   localparam int Q_W          = 17;
   localparam int Q_SHIFT      = 16;
   localparam int PROD_W       = CNT_W + Q_W;

   localparam logic [Q_W-1:0]   Q_ONE       = Q_W'(65536);
   localparam logic [CNT_W-1:0] WIN_RESET   = CNT_W'(5);
   localparam logic [CNT_W-1:0] WIN_LIMIT   = CNT_W'(WINDOW_MAX);
   localparam logic [Q_W-1:0]   Q_RESET     = Q_W'(32768);

   // configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = Q_W;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_SIZE       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_QUANTILE_FRACTION = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTERED          = 2'd2;

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;

   typedef struct packed {
      sample_type sample;
      logic       last_sample;
   } req_payload_type;

   typedef struct packed {
      sample_type quantile_value;
      logic       end_of_stream;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      OP_HOLD   = 2'd0,
      OP_INSERT = 2'd1,
      OP_EVICT  = 2'd2
   } chain_op_type;

   // contents of one cell: value and number of younger samples in the window
   typedef struct packed {
      sample_type       val;
      logic [AGE_W-1:0] age;
   } cell_data_type;

   // control from the sequencer to the chain
   typedef struct packed {
      chain_op_type     op;
      sample_type       key;
      logic [CNT_W-1:0] fill;
      logic [IDX_W-1:0] rank;
   } chain_ctl_type;

   // broadcast from the chain to every cell
   typedef struct packed {
      chain_op_type     op;
      sample_type       key;
      sample_type       evict_val;
      logic [AGE_W-1:0] evict_age;
   } cell_ctl_type;

endpackage

### hdl/rwq_cell.sv
// rwq_cell: one slot of the sorted window chain, shifts up on insert, down on evict
// depends on rwq_pkg
`timescale 1ns / 1ps

module rwq_cell import rwq_pkg::*; (
   input  logic          clock,
   input  cell_ctl_type  ctl,
   input  logic          own_valid,
   input  logic          left_ge,
   input  cell_data_type left_data,
   input  cell_data_type right_data,
   output logic          ge,
   output cell_data_type data
);

   cell_data_type data_ff;
   cell_data_type data_in;
   logic          rm;

   // chain is ordered by value, ties newest first
   assign ge = !own_valid || (data_ff.val >= ctl.key);
   assign rm = own_valid && ((data_ff.val > ctl.evict_val) ||
                ((data_ff.val == ctl.evict_val) && (data_ff.age >= ctl.evict_age)));

   always_comb begin
      data_in = data_ff;
      case (ctl.op)
         OP_INSERT: begin
            if (left_ge) begin
               data_in.val = left_data.val;
               data_in.age = AGE_W'(left_data.age + 1'b1);
            end else if (ge) begin
               data_in.val = ctl.key;
               data_in.age = '0;
            end else begin
               data_in.age = AGE_W'(data_ff.age + 1'b1);
            end
         end
         OP_EVICT: begin
            if (rm) begin
               data_in = right_data;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

### hdl/rwq_chain.sv
// rwq_chain: row of rwq_cell slots holding the sorted window, oldest lookup, rank select
// depends on rwq_pkg and rwq_cell
`timescale 1ns / 1ps

module rwq_chain import rwq_pkg::*; (
   input  logic          clock,
   input  chain_ctl_type ctl,
   output sample_type    pick_value
);

   cell_data_type           cell_data [WINDOW_MAX];
   logic [WINDOW_MAX-1:0]   cell_ge;
   logic [WINDOW_MAX-1:0]   cell_valid;
   cell_ctl_type            cell_ctl;
   logic [AGE_W-1:0]        oldest_age;
   sample_type              oldest_val;

   assign oldest_age = AGE_W'(ctl.fill - 1'b1);

   // exactly one valid cell carries the oldest age
   always_comb begin
      oldest_val = '0;
      for (int i = 0; i < WINDOW_MAX; i++) begin
         if (cell_valid[i] && (cell_data[i].age == oldest_age)) begin
            oldest_val = oldest_val | cell_data[i].val;
         end
      end
   end

   assign cell_ctl.op        = ctl.op;
   assign cell_ctl.key       = ctl.key;
   assign cell_ctl.evict_val = oldest_val;
   assign cell_ctl.evict_age = oldest_age;

   for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
      assign cell_valid[i] = (CNT_W'(i) < ctl.fill);

      if (i == 0) begin : g_first
         rwq_cell u_cell (
            .clock      (clock),
            .ctl        (cell_ctl),
            .own_valid  (cell_valid[i]),
            .left_ge    (1'b0),
            .left_data  (cell_data[i]),
            .right_data (cell_data[i+1]),
            .ge         (cell_ge[i]),
            .data       (cell_data[i])
         );
      end else if (i == WINDOW_MAX - 1) begin : g_last
         rwq_cell u_cell (
            .clock      (clock),
            .ctl        (cell_ctl),
            .own_valid  (cell_valid[i]),
            .left_ge    (cell_ge[i-1]),
            .left_data  (cell_data[i-1]),
            .right_data (cell_data[i]),
            .ge         (cell_ge[i]),
            .data       (cell_data[i])
         );
      end else begin : g_mid
         rwq_cell u_cell (
            .clock      (clock),
            .ctl        (cell_ctl),
            .own_valid  (cell_valid[i]),
            .left_ge    (cell_ge[i-1]),
            .left_data  (cell_data[i-1]),
            .right_data (cell_data[i+1]),
            .ge         (cell_ge[i]),
            .data       (cell_data[i])
         );
      end
   end

   assign pick_value = cell_data[ctl.rank].val;

endmodule

### hdl/rolling_window_quantile_unit.sv
// rolling_window_quantile_unit: top level, sequencer, config registers, result register
// sequence: the accepted sample is registered; ST_UPDATE evicts the oldest
//    sample while the window is full (more than once after it shrank), then
//    inserts it; ST_EMIT loads the result register once the output is free,
//    unless centered and at most half full; req_stall is high outside ST_IDLE
// reset (synchronous): window empty, registers to defaults, no clearing pass
`timescale 1ns / 1ps

module rolling_window_quantile_unit import rwq_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_payload_type       req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_payload_type       rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   typedef enum logic [4:0] {
      ST_IDLE        = 5'b00001,
      ST_UPDATE      = 5'b00010,
      ST_EMIT        = 5'b00100,
      ST_DRAIN_EVICT = 5'b01000,
      ST_DRAIN_EMIT  = 5'b10000
   } state_type;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     fill_ff, fill_in;
   sample_type           sample_ff;
   logic                 last_ff;
   logic [CNT_W-1:0]     win_ff;
   logic [IDX_W-1:0]     half_ff;
   logic [CNT_W-1:0]     win_size_ff;
   logic [Q_W-1:0]       quant_ff;
   logic                 centered_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_payload_type      rsp_data_ff;

   logic                 accept;
   logic [CNT_W-1:0]     win_eff;
   logic [Q_W-1:0]       quant_eff;
   logic [PROD_W-1:0]    prod;
   logic [CNT_W-1:0]     rank_raw;
   logic [IDX_W-1:0]     rank;
   logic                 out_free;
   logic                 emit_load;
   logic                 emit_end;
   logic                 more_drain;
   chain_op_type         chain_op;
   chain_ctl_type        chain_ctl;
   sample_type           pick_value;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   assign win_eff = (win_size_ff == '0) ? CNT_W'(1) :
                    (win_size_ff > WIN_LIMIT) ? WIN_LIMIT : win_size_ff;

   assign quant_eff = (quant_ff > Q_ONE) ? Q_ONE : quant_ff;
   assign prod      = PROD_W'(fill_ff) * PROD_W'(quant_eff);
   assign rank_raw  = prod[Q_SHIFT +: CNT_W];
   assign rank      = (rank_raw >= fill_ff) ? IDX_W'(fill_ff - 1'b1) : rank_raw[IDX_W-1:0];

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   // drain continues while the fill after one more eviction stays above half
   assign more_drain = centered_ff && last_ff &&
                       (CNT_W'(fill_ff - 1'b1) > CNT_W'(half_ff));

   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      emit_load     = 1'b0;
      emit_end      = 1'b0;
      chain_op      = OP_HOLD;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (fill_ff >= win_ff) begin
               chain_op = OP_EVICT;
               fill_in  = CNT_W'(fill_ff - 1'b1);
            end else begin
               chain_op = OP_INSERT;
               fill_in  = CNT_W'(fill_ff + 1'b1);
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (centered_ff && (fill_ff <= CNT_W'(half_ff))) begin
               state_in = ST_IDLE;
               if (last_ff) begin
                  fill_in = '0;
               end
            end else if (out_free) begin
               emit_load = 1'b1;
               emit_end  = last_ff && !more_drain;
               if (more_drain) begin
                  state_in = ST_DRAIN_EVICT;
               end else begin
                  state_in = ST_IDLE;
                  if (last_ff) begin
                     fill_in = '0;
                  end
               end
            end
         end
         ST_DRAIN_EVICT: begin
            chain_op = OP_EVICT;
            fill_in  = CNT_W'(fill_ff - 1'b1);
            state_in = ST_DRAIN_EMIT;
         end
         ST_DRAIN_EMIT: begin
            if (out_free) begin
               emit_load = 1'b1;
               emit_end  = !more_drain;
               if (more_drain) begin
                  state_in = ST_DRAIN_EVICT;
               end else begin
                  state_in = ST_IDLE;
                  fill_in  = '0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign chain_ctl.op   = chain_op;
   assign chain_ctl.key  = sample_ff;
   assign chain_ctl.fill = fill_ff;
   assign chain_ctl.rank = rank;

   rwq_chain u_chain (
      .clock      (clock),
      .ctl        (chain_ctl),
      .pick_value (pick_value)
   );

   assign rsp_valid_in = emit_load ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         win_size_ff  <= WIN_RESET;
         quant_ff     <= Q_RESET;
         centered_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_WINDOW_SIZE:       win_size_ff <= csr_data[CNT_W-1:0];
               CSR_QUANTILE_FRACTION: quant_ff    <= csr_data[Q_W-1:0];
               CSR_CENTERED:          centered_ff <= csr_data[0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sample_ff <= req_data.sample;
         last_ff   <= req_data.last_sample;
         win_ff    <= win_eff;
         half_ff   <= win_eff[CNT_W-1:1];
      end
      if (emit_load) begin
         rsp_data_ff.quantile_value <= pick_value;
         rsp_data_ff.end_of_stream  <= emit_end;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
